// ===== rtl/core/lwbr_pkg.sv =====
package lwbr_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int HISTORY_DEPTH_DEF = 512;

    localparam int LETTER_W = 5;
    localparam int LIMIT_W  = 4;
    localparam int CNT_W    = 5;
    localparam int LEN_W    = 10;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd2;
    localparam logic [LEN_W-1:0]   LEN_MAX   = 10'd1023;

endpackage

// ===== rtl/core/lwbr_in_if.sv =====
interface lwbr_in_if import lwbr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter_index;
    logic                first_letter;
    logic                last_letter;

    modport source (output valid, output letter_index, output first_letter,
                    output last_letter, input ready);
    modport sink   (input valid, input letter_index, input first_letter,
                    input last_letter, output ready);
endinterface

// ===== rtl/core/lwbr_out_if.sv =====
interface lwbr_out_if import lwbr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] window_length;
    logic [LEN_W-1:0] best_length;
    logic             final_result;

    modport source (output valid, output window_length, output best_length,
                    output final_result, input ready);
    modport sink   (input valid, input window_length, input best_length,
                    input final_result, output ready);
endinterface

// ===== rtl/core/longest_window_bounded_repeats_unit.sv =====
// Longest window with bounded repeats. Letters arrive one per input transaction; for each
// one the unit returns the length of the longest window ending at that letter in which no
// letter occurs more than occurrence_limit times (0 acts as 1), the best such length since
// the last first_letter mark, and the echoed last_letter mark. Letter indexes at or above
// the alphabet size are taken as the last letter; lengths saturate at 1023. Per-letter
// counts live in a small synchronous memory and the window letters in a ring memory of
// HISTORY_DEPTH entries; one letter is handled at a time. An accepted letter has its count
// read and written back incremented, and its result is registered; every letter that
// leaves the window costs one ring read, then a read-modify-write of the count memory. A
// letter arriving at a full ring first drops the oldest letter, then reads its own count
// again. Each letter leaves the window at most once. A result waiting on the sink holds off
// the next letter.
module longest_window_bounded_repeats_unit import lwbr_pkg::*; #(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    lwbr_in_if.sink            i_in,
    lwbr_out_if.source         o_out
);

    localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    localparam logic [AW-1:0] LAST_LETTER = AW'(ALPHABET_SIZE - 1);
    localparam logic [HW-1:0] LAST_SLOT   = HW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL   = FW'(HISTORY_DEPTH);
    localparam logic [FW-1:0] ONE_FILL    = FW'(1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD_R = 3'd1;
    localparam logic [2:0] S_ADD_W = 3'd2;
    localparam logic [2:0] S_DRP_C = 3'd3;
    localparam logic [2:0] S_DRP_W = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [LIMIT_W-1:0]       r_limit;
    logic [AW-1:0]            r_letter;
    logic                     r_last;
    logic                     r_pre, n_pre;
    logic [AW-1:0]            r_old;
    logic [CNT_W-1:0]         r_cur, n_cur;
    logic [HW-1:0]            r_start, n_start;
    logic [HW-1:0]            r_end, n_end;
    logic [FW-1:0]            r_fill, n_fill;
    logic [FW-1:0]            r_best, n_best;
    logic [ALPHABET_SIZE-1:0] r_cvalid, n_cvalid;

    logic [CNT_W-1:0] r_cnt_mem [ALPHABET_SIZE];
    logic [AW-1:0]    r_hist_mem [HISTORY_DEPTH];
    logic [CNT_W-1:0] r_cnt_q;
    logic [AW-1:0]    r_hist_q;

    logic             r_out_valid;
    logic [LEN_W-1:0] r_out_len;
    logic [LEN_W-1:0] r_out_best;
    logic             r_out_last;

    logic             in_acc;
    logic             done;
    logic [AW-1:0]    letter_sat;
    logic [CNT_W-1:0] lim;
    logic [AW-1:0]    cnt_sel;
    logic [CNT_W-1:0] cnt_cur;
    logic [CNT_W-1:0] cur_inc;
    logic [HW-1:0]    start_nx;
    logic [HW-1:0]    end_nx;
    logic             cnt_we;
    logic [AW-1:0]    cnt_wa;
    logic [CNT_W-1:0] cnt_wd;
    logic [AW-1:0]    cnt_ra;
    logic             hist_we;
    logic [HW-1:0]    hist_ra;

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;

    assign letter_sat = (int'(i_in.letter_index) >= ALPHABET_SIZE) ? LAST_LETTER
                                                                 : AW'(i_in.letter_index);
    assign lim      = (r_limit == '0) ? CNT_W'(1) : CNT_W'(r_limit);
    assign cnt_sel  = (r_state == S_DRP_W) ? r_old : r_letter;
    assign cnt_cur  = r_cvalid[cnt_sel] ? r_cnt_q : '0;
    assign cur_inc  = cnt_cur + CNT_W'(1);
    assign start_nx = (r_start == LAST_SLOT) ? '0 : r_start + HW'(1);
    assign end_nx   = (r_end == LAST_SLOT) ? '0 : r_end + HW'(1);

    always_comb begin
        n_state  = r_state;
        n_pre    = r_pre;
        n_cur    = r_cur;
        n_start  = r_start;
        n_end    = r_end;
        n_fill   = r_fill;
        n_best   = r_best;
        n_cvalid = r_cvalid;
        cnt_we   = 1'b0;
        cnt_wa   = r_letter;
        cnt_wd   = cur_inc;
        cnt_ra   = r_letter;
        hist_we  = 1'b0;
        hist_ra  = r_start;
        done     = 1'b0;
        case (r_state)
            S_IDLE: begin
                cnt_ra = letter_sat;
                if (in_acc) begin
                    if (i_in.first_letter) begin
                        n_start  = '0;
                        n_end    = '0;
                        n_fill   = '0;
                        n_best   = '0;
                        n_cvalid = '0;
                    end
                    if (!i_in.first_letter && r_fill == FULL_FILL) begin
                        n_pre   = 1'b1;
                        n_state = S_DRP_C;
                    end else begin
                        n_pre   = 1'b0;
                        n_state = S_ADD_W;
                    end
                end
            end
            S_ADD_R: begin
                n_state = S_ADD_W;
            end
            S_ADD_W: begin
                cnt_we             = 1'b1;
                n_cvalid[r_letter] = 1'b1;
                hist_we            = 1'b1;
                n_end              = end_nx;
                n_fill             = r_fill + ONE_FILL;
                n_cur              = cur_inc;
                if (cur_inc > lim && n_fill > ONE_FILL) begin
                    n_state = S_DRP_C;
                end else begin
                    done = 1'b1;
                end
            end
            S_DRP_C: begin
                cnt_ra  = r_hist_q;
                n_state = S_DRP_W;
            end
            S_DRP_W: begin
                if (cnt_cur != '0) begin
                    cnt_we          = 1'b1;
                    cnt_wa          = r_old;
                    cnt_wd          = cnt_cur - CNT_W'(1);
                    n_cvalid[r_old] = 1'b1;
                end
                n_start = start_nx;
                n_fill  = r_fill - ONE_FILL;
                hist_ra = start_nx;
                if (r_pre) begin
                    n_pre   = 1'b0;
                    n_state = S_ADD_R;
                end else begin
                    if (r_old == r_letter) begin
                        n_cur = r_cur - CNT_W'(1);
                    end
                    if (n_cur > lim && n_fill > ONE_FILL) begin
                        n_state = S_DRP_C;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (done) begin
            n_state = S_IDLE;
            n_best  = (n_fill > r_best) ? n_fill : r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RST;
            r_pre       <= 1'b0;
            r_start     <= '0;
            r_end       <= '0;
            r_fill      <= '0;
            r_best      <= '0;
            r_cvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pre    <= n_pre;
            r_start  <= n_start;
            r_end    <= n_end;
            r_fill   <= n_fill;
            r_best   <= n_best;
            r_cvalid <= n_cvalid;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (in_acc) begin
            r_letter <= letter_sat;
            r_last   <= i_in.last_letter;
        end
        if (r_state == S_DRP_C) begin
            r_old <= r_hist_q;
        end
        if (done) begin
            r_out_len  <= (int'(n_fill) > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(n_fill);
            r_out_best <= (int'(n_best) > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(n_best);
            r_out_last <= r_last;
        end
    end

    // per-letter count memory
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        r_cnt_q <= r_cnt_mem[cnt_ra];
    end

    // ring of window letters
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[r_end] <= r_letter;
        end
        r_hist_q <= r_hist_mem[hist_ra];
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.window_length = r_out_len;
    assign o_out.best_length   = r_out_best;
    assign o_out.final_result  = r_out_last;

endmodule

// ===== rtl/core/lwbr_checker.sv =====
module lwbr_checker import lwbr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [LEN_W-1:0] i_window_length,
    input logic [LEN_W-1:0] i_best_length,
    input logic             i_final_result
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_window_length)
            && $stable(i_best_length) && $stable(i_final_result))
        else $error("result changed while stalled");

    a_best_ge_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_best_length >= i_window_length)
        else $error("best length below window length");

    a_window_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_window_length != '0)
        else $error("empty window reported");

    // one letter at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("transaction taken while one is in flight");

endmodule

bind longest_window_bounded_repeats_unit lwbr_checker u_lwbr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_window_length (o_out.window_length),
    .i_best_length   (o_out.best_length),
    .i_final_result  (o_out.final_result)
);
